// File: sv/limit_order_matcher_defines.svh
// ---------------------------------------------------------------------------
// Limit order matcher assertion macros
// Shared shorthand for the concurrent checks on the matcher's ports.
// ---------------------------------------------------------------------------
`ifndef LIMIT_ORDER_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted during reset.
`define LOM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("limit order matcher check failed");

// Next-cycle implication, sampled on clk and muted during reset.
`define LOM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("limit order matcher check failed");

`endif

// File: sv/lom_pkg.sv
// ---------------------------------------------------------------------------
// Limit order matcher package
// Book entry layout, sequencer states and status codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lom_pkg;

  localparam logic [23:0] RESET_PRICE = 24'd10000;

  typedef struct packed {
    logic [31:0] id;
    logic [23:0] price;
    logic [31:0] amount;
    logic [31:0] tstamp;
    logic [31:0] seq;
  } entry_t;

  typedef enum logic [1:0] {
    ST_FILLED  = 2'd0,
    ST_RESTED  = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH_RD,
    S_MATCH_EV,
    S_FINISH,
    S_INS_RD,
    S_INS_EV,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: sv/lom_book_mem.sv
// ---------------------------------------------------------------------------
// Limit order matcher book memory
// One write port and one registered read port holding both sides of the book.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lom_book_mem #(
  parameter int WORDS  = 64,
  parameter int ADDR_W = 6
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [ADDR_W-1:0]     wr_addr,
  input  wire lom_pkg::entry_t wr_data,
  input  wire                  rd_en,
  input  wire [ADDR_W-1:0]     rd_addr,
  output lom_pkg::entry_t      rd_data
);
  import lom_pkg::*;

  entry_t mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/limit_order_matcher.sv
// The status request leaves after every fill of the order, after a best entry
// that does not cross, and for a resting remainder after it has moved back each
// entry ranked behind it; output stalls delay it further.
// Only one order is handled at a time.
// Reset (synchronous, rst_n low) empties both sides, zeroes the sequence
// counter and sets the last traded price to 100.00. No clearing pass is needed.
// ---------------------------------------------------------------------------
// Limit order matcher top level
// Two-sided price-time priority order book kept in one synchronous memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module limit_order_matcher #(
  parameter int BOOK_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_order_id,
  input  wire         in_is_sell,
  input  wire  [23:0] in_limit_price,
  input  wire  [31:0] in_amount,
  input  wire  [31:0] in_arrival_time,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_is_trade,
  output logic [23:0] out_trade_price,
  output logic [31:0] out_trade_amount,
  output logic [31:0] out_trade_time,
  output logic [1:0]  out_final_status,
  output logic [23:0] out_last_price,
  output logic        out_is_last
);
  import lom_pkg::*;

  // Each side is a circular buffer of BOOK_DEPTH words, sorted best first
  // from its head. Bids live in the lower half of the memory, asks above.
  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int AW = $clog2(2 * BOOK_DEPTH);

  state_t state_r, state_nxt;

  logic [31:0]   ord_id_r, ord_id_nxt;
  logic          ord_sell_r, ord_sell_nxt;
  logic [23:0]   ord_price_r, ord_price_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   ord_time_r, ord_time_nxt;
  logic [31:0]   ord_seq_r, ord_seq_nxt;
  logic [31:0]   arr_cnt_r, arr_cnt_nxt;
  logic [CW-1:0] bid_cnt_r, bid_cnt_nxt;
  logic [CW-1:0] ask_cnt_r, ask_cnt_nxt;
  logic [IW-1:0] bid_head_r, bid_head_nxt;
  logic [IW-1:0] ask_head_r, ask_head_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [23:0]   last_px_r, last_px_nxt;
  status_t       status_r, status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_trade_r, out_trade_nxt;
  logic [23:0]   out_price_r, out_price_nxt;
  logic [31:0]   out_amount_r, out_amount_nxt;
  logic [31:0]   out_time_r, out_time_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [23:0]   out_last_r, out_last_nxt;
  logic          out_end_r, out_end_nxt;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  entry_t        mem_wr_data, mem_rd_data;

  // Derived views of the current order against the two sides.
  logic [CW-1:0] opp_cnt, own_cnt;
  logic [IW-1:0] opp_head, own_head;
  logic          slot_free, crosses, new_ahead, fill_left;
  logic [31:0]   fill_qty;
  entry_t        new_entry;

  // Maps a logical position on one side to its memory address.
  function automatic logic [AW-1:0] book_addr(input logic side_ask,
                                              input logic [IW-1:0] head,
                                              input logic [IW-1:0] pos);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IW+1)'(BOOK_DEPTH)) begin
      sum = sum - (IW+1)'(BOOK_DEPTH);
    end
    book_addr = side_ask ? (AW'(BOOK_DEPTH) + AW'(sum)) : AW'(sum);
  endfunction

  // Advances a head pointer by one with wrap at the side's depth.
  function automatic logic [IW-1:0] head_inc(input logic [IW-1:0] head);
    logic [IW:0] sum;
    sum = {1'b0, head} + (IW+1)'(1);
    if (sum >= (IW+1)'(BOOK_DEPTH)) begin
      sum = '0;
    end
    head_inc = sum[IW-1:0];
  endfunction

  assign opp_cnt  = ord_sell_r ? bid_cnt_r  : ask_cnt_r;
  assign own_cnt  = ord_sell_r ? ask_cnt_r  : bid_cnt_r;
  assign opp_head = ord_sell_r ? bid_head_r : ask_head_r;
  assign own_head = ord_sell_r ? ask_head_r : bid_head_r;

  // The result register can take a new request when empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  // A sell crosses a bid at or above its limit; a buy an ask at or below.
  assign crosses = ord_sell_r ? (mem_rd_data.price >= ord_price_r)
                              : (mem_rd_data.price <= ord_price_r);
  assign fill_left = mem_rd_data.amount > rem_r;
  assign fill_qty  = fill_left ? rem_r : mem_rd_data.amount;

  // Price first, then time, then arrival sequence decides book priority.
  always_comb begin
    if (ord_price_r != mem_rd_data.price) begin
      new_ahead = ord_sell_r ? (ord_price_r < mem_rd_data.price)
                             : (ord_price_r > mem_rd_data.price);
    end else if (ord_time_r != mem_rd_data.tstamp) begin
      new_ahead = ord_time_r < mem_rd_data.tstamp;
    end else begin
      new_ahead = ord_seq_r < mem_rd_data.seq;
    end
  end

  assign new_entry = '{id: ord_id_r, price: ord_price_r, amount: rem_r,
                       tstamp: ord_time_r, seq: ord_seq_r};

  // Next state of the order sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MATCH_RD;
        end
      end
      S_MATCH_RD: begin
        if (rem_r != '0 && opp_cnt != '0) begin
          state_nxt = S_MATCH_EV;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MATCH_EV: begin
        if (!crosses) begin
          state_nxt = S_FINISH;
        end else if (slot_free) begin
          state_nxt = S_MATCH_RD;
        end
      end
      S_FINISH: begin
        if (rem_r != '0 && own_cnt < CW'(BOOK_DEPTH)) begin
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_INS_EV;
        end
      end
      S_INS_EV: begin
        if (new_ahead) begin
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory requests and result register loads.
  always_comb begin
    ord_id_nxt     = ord_id_r;
    ord_sell_nxt   = ord_sell_r;
    ord_price_nxt  = ord_price_r;
    rem_nxt        = rem_r;
    ord_time_nxt   = ord_time_r;
    ord_seq_nxt    = ord_seq_r;
    arr_cnt_nxt    = arr_cnt_r;
    bid_cnt_nxt    = bid_cnt_r;
    ask_cnt_nxt    = ask_cnt_r;
    bid_head_nxt   = bid_head_r;
    ask_head_nxt   = ask_head_r;
    idx_nxt        = idx_r;
    last_px_nxt    = last_px_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_trade_nxt  = out_trade_r;
    out_price_nxt  = out_price_r;
    out_amount_nxt = out_amount_r;
    out_time_nxt   = out_time_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_end_nxt    = out_end_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = '0;
    mem_wr_data    = new_entry;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ord_id_nxt    = in_order_id;
          ord_sell_nxt  = in_is_sell;
          ord_price_nxt = in_limit_price;
          rem_nxt       = in_amount;
          ord_time_nxt  = in_arrival_time;
          ord_seq_nxt   = arr_cnt_r;
          arr_cnt_nxt   = arr_cnt_r + 32'd1;
        end
      end
      S_MATCH_RD: begin
        if (rem_r != '0 && opp_cnt != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = book_addr(!ord_sell_r, opp_head, '0);
        end
      end
      S_MATCH_EV: begin
        if (crosses && slot_free) begin
          out_valid_nxt  = 1'b1;
          out_trade_nxt  = 1'b1;
          out_price_nxt  = mem_rd_data.price;
          out_amount_nxt = fill_qty;
          out_time_nxt   = ord_time_r;
          out_status_nxt = ST_FILLED;
          out_last_nxt   = mem_rd_data.price;
          out_end_nxt    = 1'b0;
          last_px_nxt    = mem_rd_data.price;
          rem_nxt        = rem_r - fill_qty;
          if (fill_left) begin
            // Partial fill of the best entry: it keeps its place.
            mem_wr_en          = 1'b1;
            mem_wr_addr        = book_addr(!ord_sell_r, opp_head, '0);
            mem_wr_data        = mem_rd_data;
            mem_wr_data.amount = mem_rd_data.amount - fill_qty;
          end else if (ord_sell_r) begin
            bid_head_nxt = head_inc(bid_head_r);
            bid_cnt_nxt  = bid_cnt_r - CW'(1);
          end else begin
            ask_head_nxt = head_inc(ask_head_r);
            ask_cnt_nxt  = ask_cnt_r - CW'(1);
          end
        end
      end
      S_FINISH: begin
        idx_nxt = own_cnt;
        if (rem_r == '0) begin
          status_nxt = ST_FILLED;
        end else if (own_cnt < CW'(BOOK_DEPTH)) begin
          status_nxt = ST_RESTED;
        end else begin
          status_nxt = ST_DROPPED;
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = book_addr(ord_sell_r, own_head, '0);
          if (ord_sell_r) begin
            ask_cnt_nxt = ask_cnt_r + CW'(1);
          end else begin
            bid_cnt_nxt = bid_cnt_r + CW'(1);
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = book_addr(ord_sell_r, own_head, idx_r[IW-1:0] - IW'(1));
        end
      end
      S_INS_EV: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = book_addr(ord_sell_r, own_head, idx_r[IW-1:0]);
        if (new_ahead) begin
          // The stored entry moves one place back to open the slot.
          mem_wr_data = mem_rd_data;
          idx_nxt     = idx_r - CW'(1);
        end else if (ord_sell_r) begin
          ask_cnt_nxt = ask_cnt_r + CW'(1);
        end else begin
          bid_cnt_nxt = bid_cnt_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_trade_nxt  = 1'b0;
          out_price_nxt  = '0;
          out_amount_nxt = rem_r;
          out_time_nxt   = ord_time_r;
          out_status_nxt = status_r;
          out_last_nxt   = last_px_r;
          out_end_nxt    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arr_cnt_r   <= '0;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      bid_head_r  <= '0;
      ask_head_r  <= '0;
      last_px_r   <= RESET_PRICE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arr_cnt_r   <= arr_cnt_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      bid_head_r  <= bid_head_nxt;
      ask_head_r  <= ask_head_nxt;
      last_px_r   <= last_px_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ord_id_r     <= ord_id_nxt;
    ord_sell_r   <= ord_sell_nxt;
    ord_price_r  <= ord_price_nxt;
    rem_r        <= rem_nxt;
    ord_time_r   <= ord_time_nxt;
    ord_seq_r    <= ord_seq_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    out_trade_r  <= out_trade_nxt;
    out_price_r  <= out_price_nxt;
    out_amount_r <= out_amount_nxt;
    out_time_r   <= out_time_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_end_r    <= out_end_nxt;
  end

  lom_book_mem #(
    .WORDS  (2 * BOOK_DEPTH),
    .ADDR_W (AW)
  ) u_book (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // A new request is taken only while the sequencer waits for one.
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_is_trade     = out_trade_r;
  assign out_trade_price  = out_price_r;
  assign out_trade_amount = out_amount_r;
  assign out_trade_time   = out_time_r;
  assign out_final_status = out_status_r;
  assign out_last_price   = out_last_r;
  assign out_is_last      = out_end_r;

endmodule

`default_nettype wire

// File: sv/lom_checker.sv
// ---------------------------------------------------------------------------
// Limit order matcher port checker
// Watches the matcher's ports and is bound to every instance of it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_matcher_defines.svh"

module lom_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        out_is_trade,
  input wire [23:0] out_trade_price,
  input wire [1:0]  out_final_status,
  input wire [23:0] out_last_price,
  input wire        out_is_last
);
  import lom_pkg::*;

  `LOM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `LOM_ASSERT_NXT(a_one_order, in_valid && !in_stall, in_stall)
  `LOM_ASSERT_IMP(a_last_is_status, out_valid, out_is_last == !out_is_trade)
  `LOM_ASSERT_IMP(a_trade_moves_last, out_valid && out_is_trade, out_trade_price == out_last_price && out_final_status == ST_FILLED)
  `LOM_ASSERT_IMP(a_status_code, out_valid && !out_is_trade, out_final_status != 2'd3 && out_trade_price == 24'd0)

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_is_trade     (out_is_trade),
  .out_trade_price  (out_trade_price),
  .out_final_status (out_final_status),
  .out_last_price   (out_last_price),
  .out_is_last      (out_is_last)
);

`default_nettype wire

// File: tb/sv/tb_limit_order_matcher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Limit order matcher testbench
// Drives limit orders into the matcher with random gaps and output stalls,
// predicts every fill and status with a behavioral copy of the order book,
// and compares each result against the oldest pending prediction.
// ---------------------------------------------------------------------------

module tb_limit_order_matcher;
  import lom_pkg::*;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  // One predicted output item of the matcher.
  typedef struct {
    logic        is_trade;
    logic [23:0] price;
    logic [31:0] amount;
    logic [31:0] tstamp;
    status_t     status;
    logic [23:0] last_price;
    logic        is_last;
  } fill_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_order_id = '0;
  logic        in_is_sell = 1'b0;
  logic [23:0] in_limit_price = '0;
  logic [31:0] in_amount = '0;
  logic [31:0] in_arrival_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_trade;
  logic [23:0] out_trade_price;
  logic [31:0] out_trade_amount;
  logic [31:0] out_trade_time;
  logic [1:0]  out_final_status;
  logic [23:0] out_last_price;
  logic        out_is_last;

  // The model's copy of the book: index 0 holds the best entry of each side.
  entry_t      bids[DEPTH];
  entry_t      asks[DEPTH];
  int          bid_cnt;
  int          ask_cnt;
  logic [31:0] next_seq;
  logic [23:0] last_traded;

  fill_t       pending_fills[$];
  int          mismatches;
  int          orders_sent;
  int          results_seen;
  int          idle_cycles;
  bit          out_noise_on;

  limit_order_matcher #(.BOOK_DEPTH(DEPTH)) DUT (.*);

  always #5 clk = ~clk;

  // Gap length: mostly zero or short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Is (p, t, s) strictly ahead of entry e on the given side?
  function automatic bit ranks_ahead(bit ask_side, logic [23:0] p, logic [31:0] t,
                                     logic [31:0] s, entry_t e);
    if (p != e.price) return ask_side ? (p < e.price) : (p > e.price);
    if (t != e.tstamp) return t < e.tstamp;
    return s < e.seq;
  endfunction

  // Walk the opposite side while prices cross, then rest or drop the remainder.
  task automatic predict_order(logic [31:0] id, bit sell, logic [23:0] price,
                               logic [31:0] amt, logic [31:0] tstamp);
    logic [31:0] rem;
    logic [31:0] qty;
    logic [31:0] seq;
    entry_t      fresh;
    fill_t       f;
    int          pos;
    int          opp_cnt;
    entry_t      top;
    rem = amt;
    seq = next_seq;
    next_seq = next_seq + 1;
    forever begin
      opp_cnt = sell ? bid_cnt : ask_cnt;
      if (rem == 0 || opp_cnt == 0) break;
      top = sell ? bids[0] : asks[0];
      if (sell ? (top.price < price) : (top.price > price)) break;
      qty = (top.amount < rem) ? top.amount : rem;
      last_traded = top.price;
      f = '{1'b1, top.price, qty, tstamp, ST_FILLED, last_traded, 1'b0};
      pending_fills.insert(pending_fills.size(), f);
      if (top.amount > qty) begin
        if (sell) bids[0].amount = top.amount - qty;
        else asks[0].amount = top.amount - qty;
      end else begin
        for (int i = 1; i < opp_cnt; i++) begin
          if (sell) bids[i - 1] = bids[i];
          else asks[i - 1] = asks[i];
        end
        if (sell) bid_cnt--;
        else ask_cnt--;
      end
      rem = rem - qty;
    end
    f = '{1'b0, 24'd0, rem, tstamp, ST_FILLED, 24'd0, 1'b1};
    if (rem != 0) begin
      if ((sell ? ask_cnt : bid_cnt) < DEPTH) begin
        fresh = '{id, price, rem, tstamp, seq};
        pos = 0;
        if (sell) begin
          while (pos < ask_cnt && !ranks_ahead(1'b1, price, tstamp, seq, asks[pos])) pos++;
          for (int i = ask_cnt; i > pos; i--) asks[i] = asks[i - 1];
          asks[pos] = fresh;
          ask_cnt++;
        end else begin
          while (pos < bid_cnt && !ranks_ahead(1'b0, price, tstamp, seq, bids[pos])) pos++;
          for (int i = bid_cnt; i > pos; i--) bids[i] = bids[i - 1];
          bids[pos] = fresh;
          bid_cnt++;
        end
        f.status = ST_RESTED;
      end else begin
        f.status = ST_DROPPED;
      end
    end
    f.last_price = last_traded;
    pending_fills.insert(pending_fills.size(), f);
  endtask

  // Send one request: hold it until the matcher takes it, then predict it.
  task automatic send_order(logic [31:0] id, bit sell, logic [23:0] price,
                            logic [31:0] amt, logic [31:0] tstamp);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_order_id = id;
    in_is_sell = sell;
    in_limit_price = price;
    in_amount = amt;
    in_arrival_time = tstamp;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_order(id, sell, price, amt, tstamp);
    orders_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_fills.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    fill_t want;
    bit    bad;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_fills.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result with nothing pending");
      end else begin
        want = pending_fills.pop_front();
        bad = (out_is_trade !== want.is_trade) || (out_trade_price !== want.price) ||
              (out_trade_amount !== want.amount) || (out_trade_time !== want.tstamp) ||
              (out_final_status !== want.status) || (out_last_price !== want.last_price) ||
              (out_is_last !== want.is_last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp trade=%0d px=%0d amt=%0d t=%0d st=%0d last=%0d end=%0d",
                     want.is_trade, want.price, want.amount, want.tstamp, want.status,
                     want.last_price, want.is_last,
                     " / got trade=%0d px=%0d amt=%0d t=%0d st=%0d last=%0d end=%0d",
                     out_is_trade, out_trade_price, out_trade_amount, out_trade_time,
                     out_final_status, out_last_price, out_is_last);
        end
      end
    end
  end

  // Output stalls come in random bursts with calm stretches between them.
  always @(negedge clk) begin
    if (!out_noise_on) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 8) begin
      out_stall <= 1'b1;
    end else if (out_stall && $urandom_range(0, 9) < 7) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which neither channel accepts a request.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results pending", pending_fills.size());
      $display("limit_order_matcher verification failed");
      $finish;
    end
  end

  // Extremes of every field, equal-price crossing, partial fills of a resting
  // entry, zero amount and a sell that sweeps a deep book.
  task automatic test_directed();
    send_order(32'hFFFF_FFFF, 1'b0, 24'hFFFFFF, 32'd5, 32'hFFFF_FFFF);
    send_order(32'd1, 1'b1, 24'd0, 32'd3, 32'd0);
    send_order(32'd2, 1'b1, 24'd0, 32'd0, 32'd7);
    send_order(32'd3, 1'b1, 24'd500, 32'hFFFF_FFFF, 32'd10);
    send_order(32'd4, 1'b0, 24'd500, 32'd10, 32'd11);
    send_order(32'd5, 1'b0, 24'd499, 32'd10, 32'd12);
    send_order(32'd6, 1'b0, 24'd499, 32'd10, 32'd12);
    send_order(32'd7, 1'b0, 24'd499, 32'd10, 32'd9);
    send_order(32'd8, 1'b1, 24'd499, 32'd25, 32'd13);
    send_order(32'd9, 1'b0, 24'hFFFFFF, 32'hFFFF_FFFF, 32'd14);
  endtask

  // Fill the bid side to its limit so further buys are dropped, then sweep.
  task automatic test_side_full();
    for (int i = 0; i < DEPTH + 2; i++)
      send_order($urandom, 1'b0, 24'd100 + 24'($urandom_range(0, 3)), 32'd2, 32'($urandom_range(0, 5)));
    send_order(32'hABCD, 1'b1, 24'd1, 32'd1000, 32'd77);
  endtask

  // Random orders clustered just above price 1000 so books cross often; a few
  // carry fully random fields to toggle every bit.
  task automatic test_random();
    logic [23:0] p;
    logic [31:0] a;
    for (int n = 0; n < 55; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        p = 24'($urandom);
        a = $urandom;
      end else begin
        p = 24'd1000 + 24'($urandom_range(0, 40));
        a = $urandom_range(0, 9) == 0 ? 32'd0 : 32'($urandom_range(1, 60));
      end
      send_order($urandom, 1'($urandom_range(0, 1)), p, a,
                 $urandom_range(0, 1) ? $urandom : 32'(n));
    end
  endtask

  initial begin
    bid_cnt = 0;
    ask_cnt = 0;
    next_seq = '0;
    last_traded = RESET_PRICE;
    mismatches = 0;
    orders_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    out_noise_on = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_drained();
    out_noise_on = 1'b1;
    test_side_full();
    wait_drained();
    test_random();
    wait_drained();
    out_noise_on = 1'b0;
    repeat (200) @(negedge clk);

    $display("Sent %0d orders and checked %0d results, including crossing sweeps,",
             orders_sent, results_seen);
    $display("partial fills, zero amounts and a full book side.");
    if (mismatches == 0 && pending_fills.size() == 0) begin
      $display("limit_order_matcher verification clean");
    end else begin
      $display("limit_order_matcher verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lom_pkg.sv
sv/lom_book_mem.sv
sv/limit_order_matcher.sv
sv/lom_checker.sv
tb/sv/tb_limit_order_matcher.sv
